@@ rtl/bole_pkg.sv @@
// Shared constants, codes, field positions and the cell control bundle of the list engine.
`default_nettype none

package bole_pkg;

    // List size and derived widths.
    localparam int LIST_CAPACITY = 64;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);
    localparam int POS_W         = 8;
    localparam int CMP_W         = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Reduction tree: cells are gathered in groups of eight.
    localparam int GROUP       = 8;
    localparam int GROUP_W     = 3;
    localparam int NUM_GROUPS  = (LIST_CAPACITY + GROUP - 1) / GROUP;

    // Request kinds.
    localparam logic [2:0] OP_SELECT  = 3'd0;
    localparam logic [2:0] OP_SEARCH  = 3'd1;
    localparam logic [2:0] OP_INSERT  = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_REPLACE = 3'd4;

    // Widths of the result fields.
    localparam int POSOUT_W = 7;

    // Request word layout, lowest bit first.
    localparam int IN_TYPE_LSB  = 0;
    localparam int IN_POS_LSB   = 3;
    localparam int IN_DATA_LSB  = 11;
    localparam int IN_TDATA_W   = 48;

    // Result word layout, lowest bit first.
    localparam int OUT_OK_BIT     = 0;
    localparam int OUT_READ_LSB   = 1;
    localparam int OUT_FOUND_LSB  = 33;
    localparam int OUT_COUNT_LSB  = 40;
    localparam int OUT_EMPTY_BIT  = 47;
    localparam int OUT_FULL_BIT   = 48;
    localparam int OUT_TDATA_W    = 56;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              capture;
        logic              insert_en;
        logic              remove_en;
        logic              replace_en;
        logic              select_en;
        logic              search_en;
        logic [IDX_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] data;
    } bole_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/bounded_ordered_list_engine_core.sv @@
// Top level of the bounded ordered list engine: request sequencer, cell chain and result register.
//
//  Channel | Direction | Signals                  | Carries
//  --------+-----------+--------------------------+------------------------------------------
//  s_      | in        | tvalid, tready, tdata 48 | one request: kind, position, data word
//  m_      | out       | tvalid, tready, tdata 56 | one result per request
//
// Every request passes through the accept cycle, in which all cells shift or
// overwrite in parallel and capture their hit flags, then through each level
// of the gather tree that picks the first hit among the cells.
// Reset clears the element count and the handshake state; cell contents are not reset.
// A result waiting in the output register does not block the next request; the
// sequencer only holds in its last step while that register is still occupied.
`default_nettype none

module bounded_ordered_list_engine_core
    import bole_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [2:0] req_type, [10:3] position, [42:11] data_value
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [0] ok, [32:1] read_value, [39:33] found_position, [46:40] element_count,
    // [47] is_empty, [48] is_full
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PASS1 = 2'd1;
    localparam logic [1:0] S_PASS2 = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [2:0]             op_reg;
    logic [2:0]             op_next;
    logic                   ok_reg;
    logic                   ok_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic [2:0]        req_type;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_value;
    logic              accept;
    logic [CMP_W-1:0]  pos_cmp;
    logic [CMP_W-1:0]  cnt_cmp;
    logic [IDX_W-1:0]  select_target;
    bole_ctrl_t        ctrl;

    logic              cell_hit   [LIST_CAPACITY];
    logic [WORD_W-1:0] cell_value [LIST_CAPACITY];
    logic              any_hit;
    logic [IDX_W-1:0]  first_index;
    logic [WORD_W-1:0] hit_word;

    logic              res_ok;
    logic [WORD_W-1:0] res_read;
    logic [POSOUT_W-1:0] res_found;
    logic              slot_free;

    // Request fields.
    assign req_type   = s_tdata[IN_TYPE_LSB +: 3];
    assign position   = s_tdata[IN_POS_LSB +: POS_W];
    assign data_value = s_tdata[IN_DATA_LSB +: WORD_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pos_cmp  = CMP_W'(position);
    assign cnt_cmp  = CMP_W'(count_reg);

    // A select past the end reads the last element.
    assign select_target = (pos_cmp < cnt_cmp) ? IDX_W'(position)
                                               : IDX_W'(count_reg - 1'b1);

    // Decode the request into cell controls, acceptance and the new count.
    always_comb
    begin
        ctrl            = '0;
        ctrl.capture    = accept;
        ctrl.pos        = IDX_W'(position);
        ctrl.count      = count_reg;
        ctrl.data       = data_value;
        ok_next         = ok_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        if (accept)
        begin
            op_next = req_type;
            unique case (req_type)
                OP_SELECT:
                begin
                    ok_next        = (count_reg != '0);
                    ctrl.select_en = ok_next;
                    ctrl.pos       = select_target;
                end
                OP_SEARCH:
                begin
                    ok_next        = 1'b1;
                    ctrl.search_en = 1'b1;
                end
                OP_INSERT:
                begin
                    ok_next        = (pos_cmp <= cnt_cmp) &&
                                     (CMP_W'(count_reg) < CMP_W'(LIST_CAPACITY));
                    ctrl.insert_en = ok_next;
                    if (ok_next)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    ok_next        = (pos_cmp < cnt_cmp);
                    ctrl.remove_en = ok_next;
                    if (ok_next)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_REPLACE:
                begin
                    ok_next         = (pos_cmp < cnt_cmp);
                    ctrl.replace_en = ok_next;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // Chain of cells, each fed by both neighbours.
    for (genvar i = 0; i < LIST_CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_value[i-1];
        end

        if (i == LIST_CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_value[i+1];
        end

        bole_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .cell_index  (IDX_W'(i)),
            .left_value  (left_w),
            .right_value (right_w),
            .value       (cell_value[i]),
            .hit         (cell_hit[i])
        );
    end

    bole_reduce u_reduce (
        .clk         (clk),
        .hits        (cell_hit),
        .words       (cell_value),
        .any_hit     (any_hit),
        .first_index (first_index),
        .hit_word    (hit_word)
    );

    // Result fields from the gather tree.
    always_comb
    begin
        res_ok    = ok_reg;
        res_read  = '0;
        res_found = '0;
        if ((op_reg == OP_SELECT) && ok_reg)
        begin
            res_read = hit_word;
        end
        if (op_reg == OP_SEARCH)
        begin
            res_found = any_hit ? POSOUT_W'(first_index) : POSOUT_W'(count_reg);
        end
    end

    assign slot_free = !out_valid_reg || m_tready;

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PASS1;
                end
            end
            S_PASS1:
            begin
                state_next = S_PASS2;
            end
            S_PASS2:
            begin
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({
                        (CMP_W'(count_reg) == CMP_W'(LIST_CAPACITY)),
                        (count_reg == '0),
                        POSOUT_W'(count_reg),
                        res_found,
                        res_read,
                        res_ok
                    });
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/bole_cell.sv @@
// One list cell: holds a word, shifts with its neighbours and flags a hit for the gather tree.
`default_nettype none

module bole_cell
    import bole_pkg::*;
(
    input  wire logic              clk,
    input  wire bole_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire logic [WORD_W-1:0] left_value,
    input  wire logic [WORD_W-1:0] right_value,
    output logic      [WORD_W-1:0] value,
    output logic                   hit
);

    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;
    logic              hit_reg;
    logic              hit_next;

    // Stored word: shift up on insert, down on remove, overwrite at the position.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert_en && (cell_index > ctrl.pos))
        begin
            value_next = left_value;
        end
        if (ctrl.remove_en && (cell_index >= ctrl.pos))
        begin
            value_next = right_value;
        end
        if ((ctrl.insert_en || ctrl.replace_en) && (cell_index == ctrl.pos))
        begin
            value_next = ctrl.data;
        end
    end

    // Hit flag: addressed for select, matching and held for search.
    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.capture)
        begin
            hit_next = (ctrl.select_en && (cell_index == ctrl.pos)) ||
                       (ctrl.search_en && (value_reg == ctrl.data) &&
                        (CNT_W'(cell_index) < ctrl.count));
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hit_reg   <= hit_next;
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

@@ rtl/bole_reduce.sv @@
// Two-level gather tree: finds the first hit cell and collects the OR of the hit cells' words.
`default_nettype none

module bole_reduce
    import bole_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              hits       [LIST_CAPACITY],
    input  wire logic [WORD_W-1:0] words      [LIST_CAPACITY],
    output logic                   any_hit,
    output logic      [IDX_W-1:0]  first_index,
    output logic      [WORD_W-1:0] hit_word
);

    logic               grp_any_reg   [NUM_GROUPS];
    logic [GROUP_W-1:0] grp_idx_reg   [NUM_GROUPS];
    logic [WORD_W-1:0]  grp_word_reg  [NUM_GROUPS];
    logic               grp_any_next  [NUM_GROUPS];
    logic [GROUP_W-1:0] grp_idx_next  [NUM_GROUPS];
    logic [WORD_W-1:0]  grp_word_next [NUM_GROUPS];

    // First level: within each group of eight, the lowest hit and the OR of hit words.
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_any_next[g]  = 1'b0;
            grp_idx_next[g]  = '0;
            grp_word_next[g] = '0;
            for (int k = GROUP - 1; k >= 0; k--)
            begin
                if ((g * GROUP + k) < LIST_CAPACITY)
                begin
                    if (hits[g * GROUP + k])
                    begin
                        grp_any_next[g]  = 1'b1;
                        grp_idx_next[g]  = GROUP_W'(k);
                        grp_word_next[g] = grp_word_next[g] | words[g * GROUP + k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_any_reg[g]  <= grp_any_next[g];
            grp_idx_reg[g]  <= grp_idx_next[g];
            grp_word_reg[g] <= grp_word_next[g];
        end
    end

    // Second level: the lowest group with a hit wins.
    always_comb
    begin
        any_hit     = 1'b0;
        first_index = '0;
        hit_word    = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                any_hit     = 1'b1;
                first_index = IDX_W'(g * GROUP + int'(grp_idx_reg[g]));
            end
            hit_word = hit_word | grp_word_reg[g];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bole_checker.sv @@
// Port-level checks on the list engine, bound to its top level.
`default_nettype none

module bole_checker
    import bole_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [POSOUT_W-1:0] found_f;
    logic [POSOUT_W-1:0] count_f;

    assign found_f = m_tdata[OUT_FOUND_LSB +: POSOUT_W];
    assign count_f = m_tdata[OUT_COUNT_LSB +: POSOUT_W];

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: the input closes after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_EMPTY_BIT] == (count_f == '0)))
        else $error("empty flag disagrees with count");

    // A search result never lies past the count.
    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (found_f <= count_f))
        else $error("found position beyond count");

    // A rejected request reads nothing.
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OUT_OK_BIT] |-> (m_tdata[OUT_READ_LSB +: WORD_W] == '0))
        else $error("rejected request carries a read value");

endmodule

bind bounded_ordered_list_engine_core bole_checker u_bole_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ sim/tb_bounded_ordered_list_engine_core.sv @@
// Self-checking testbench for the bounded ordered list engine core.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine_core;
    import bole_pkg::*;

    // Request kinds past replace are not defined and must be rejected.
    localparam logic [2:0] KIND_FIRST_UNUSED = OP_REPLACE + 3'd1;
    localparam logic [2:0] KIND_LAST_UNUSED  = 3'b111;
    localparam int         MAX_WAIT          = 13;
    localparam int         LONG_HOLD         = 400;
    localparam int         SEGMENT_ITEMS     = 190;
    localparam int         NUM_SEGMENTS      = 9;
    localparam int         MAX_REPORTS       = 10;

    typedef struct {
        logic [2:0]        kind;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] value;
    } list_req_t;

    typedef struct {
        logic                ok;
        logic [WORD_W-1:0]   read_value;
        logic [POSOUT_W-1:0] found_position;
        logic [POSOUT_W-1:0] element_count;
        logic                is_empty;
        logic                is_full;
    } list_reply_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} churn_mode_t;

    // Shadow copy of the list, and the replies still owed by the block.
    class list_scoreboard;
        logic [WORD_W-1:0] cells [LIST_CAPACITY];
        int unsigned       held;
        list_reply_t       expected_replies [$];
        int unsigned       failures;

        function new();
            held     = 0;
            failures = 0;
        endfunction

        // Apply one accepted request to the shadow list and queue its reply.
        function void note_request(list_req_t r);
            list_reply_t rep;
            int unsigned found;
            rep   = '{default: '0};
            found = 0;
            case (r.kind)
                OP_SELECT:
                begin
                    if (held > 0)
                    begin
                        rep.ok         = 1'b1;
                        rep.read_value = (r.position < held) ? cells[r.position]
                                                             : cells[held - 1];
                    end
                end
                OP_SEARCH:
                begin
                    rep.ok = 1'b1;
                    found  = held;
                    for (int i = 0; i < held; i++)
                    begin
                        if (cells[i] == r.value)
                        begin
                            found = i;
                            break;
                        end
                    end
                end
                OP_INSERT:
                begin
                    if (r.position <= held && held < LIST_CAPACITY)
                    begin
                        for (int i = held; i > r.position; i--)
                            cells[i] = cells[i - 1];
                        cells[r.position] = r.value;
                        held++;
                        rep.ok = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (r.position < held)
                    begin
                        for (int i = r.position; i + 1 < held; i++)
                            cells[i] = cells[i + 1];
                        held--;
                        rep.ok = 1'b1;
                    end
                end
                OP_REPLACE:
                begin
                    if (r.position < held)
                    begin
                        cells[r.position] = r.value;
                        rep.ok = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            rep.found_position = found[POSOUT_W-1:0];
            rep.element_count  = held[POSOUT_W-1:0];
            rep.is_empty       = (held == 0);
            rep.is_full        = (held == LIST_CAPACITY);
            expected_replies.push_back(rep);
        endfunction

        function void flag(string field, longint unsigned exp, longint unsigned act);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("mismatch at %0t: %s expected %0h, got %0h", $realtime, field, exp, act);
        endfunction

        // Compare one reply from the block with the oldest outstanding one.
        function void check_reply(logic [OUT_TDATA_W-1:0] word);
            list_reply_t exp;
            if (expected_replies.size() == 0)
            begin
                flag("unexpected reply", 0, word);
                return;
            end
            exp = expected_replies.pop_front();
            if (word[OUT_OK_BIT] !== exp.ok)
                flag("ok", exp.ok, word[OUT_OK_BIT]);
            if (word[OUT_READ_LSB +: WORD_W] !== exp.read_value)
                flag("read_value", exp.read_value, word[OUT_READ_LSB +: WORD_W]);
            if (word[OUT_FOUND_LSB +: POSOUT_W] !== exp.found_position)
                flag("found_position", exp.found_position, word[OUT_FOUND_LSB +: POSOUT_W]);
            if (word[OUT_COUNT_LSB +: POSOUT_W] !== exp.element_count)
                flag("element_count", exp.element_count, word[OUT_COUNT_LSB +: POSOUT_W]);
            if (word[OUT_EMPTY_BIT] !== exp.is_empty)
                flag("is_empty", exp.is_empty, word[OUT_EMPTY_BIT]);
            if (word[OUT_FULL_BIT] !== exp.is_full)
                flag("is_full", exp.is_full, word[OUT_FULL_BIT]);
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    list_scoreboard sb = new();

    // Idling controls shared between the stimulus and the two handshake sides.
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    bit long_hold = 1'b0;

    bounded_ordered_list_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Offer one request after a random gap, or none while sending calmly, and note it once it is taken.
    task automatic offer_request(input list_req_t r);
        logic [IN_TDATA_W-1:0] word;
        int gap;
        word                           = '0;
        word[IN_TYPE_LSB +: 3]         = r.kind;
        word[IN_POS_LSB +: POS_W]      = r.position;
        word[IN_DATA_LSB +: WORD_W]    = r.value;
        gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(r);
    endtask

    // Draw one request whose mix depends on whether the list is being filled or drained.
    function automatic list_req_t random_request(churn_mode_t mode);
        list_req_t   r;
        int unsigned roll;
        int unsigned n_insert;
        int unsigned n_remove;
        int unsigned held;
        held = sb.held;
        case (mode)
            MODE_FILL:  begin n_insert = 60; n_remove = 10; end
            MODE_DRAIN: begin n_insert = 10; n_remove = 60; end
            default:    begin n_insert = 25; n_remove = 25; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < n_insert)
            r.kind = OP_INSERT;
        else if (roll < n_insert + n_remove)
            r.kind = OP_REMOVE;
        else if (roll >= 95)
            r.kind = 3'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
        else
            case (roll % 3)
                0:       r.kind = OP_SELECT;
                1:       r.kind = OP_SEARCH;
                default: r.kind = OP_REPLACE;
            endcase

        // Mostly valid positions, some just past the end and a few anywhere.
        roll = $urandom_range(0, 99);
        if (roll < 5)
            r.position = POS_W'($urandom);
        else if (roll < 15)
            r.position = POS_W'(held + $urandom_range(0, 1));
        else if (r.kind == OP_INSERT)
            r.position = POS_W'($urandom_range(0, held));
        else
            r.position = (held > 0) ? POS_W'($urandom_range(0, held - 1)) : '0;

        // Small value pool so that duplicates and first-match searches occur.
        if (r.kind == OP_SEARCH && held > 0 && $urandom_range(0, 1) == 1)
            r.value = sb.cells[$urandom_range(0, held - 1)];
        else if ($urandom_range(0, 2) == 0)
            case ($urandom_range(0, 3))
                0:       r.value = '0;
                1:       r.value = '1;
                2:       r.value = 32'h8000_0000;
                default: r.value = WORD_W'($urandom_range(0, 7));
            endcase
        else
            r.value = $urandom;
        return r;
    endfunction

    // Receiver: random stalls, with one long hold-off on request.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                stall     = LONG_HOLD;
            end
            else
                stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata);
    end

    // Main stimulus.
    initial
    begin
        list_req_t   directed [$];
        churn_mode_t modes [NUM_SEGMENTS];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: empty list, edges of insert and remove, misses and bad kinds.
        directed = '{
            '{OP_SELECT,  8'd0,   32'h0000_0000},
            '{OP_SEARCH,  8'd0,   32'h0000_0000},
            '{OP_REMOVE,  8'd0,   32'h0000_0000},
            '{OP_REPLACE, 8'd0,   32'h1111_1111},
            '{OP_INSERT,  8'd1,   32'h2222_2222},
            '{OP_INSERT,  8'd0,   32'hFFFF_FFFF},
            '{OP_INSERT,  8'd1,   32'h0000_0000},
            '{OP_INSERT,  8'd1,   32'h1234_5678},
            '{OP_INSERT,  8'd0,   32'h0000_0000},
            '{OP_SEARCH,  8'd0,   32'h0000_0000},
            '{OP_SEARCH,  8'd0,   32'hDEAD_BEEF},
            '{OP_SELECT,  8'd255, 32'h0000_0000},
            '{OP_SELECT,  8'd2,   32'hFFFF_FFFF},
            '{OP_REPLACE, 8'd3,   32'hA5A5_A5A5},
            '{OP_REPLACE, 8'd4,   32'h5A5A_5A5A},
            '{OP_REMOVE,  8'd4,   32'h0000_0000},
            '{OP_REMOVE,  8'd0,   32'h0000_0000},
            '{OP_REMOVE,  8'd2,   32'h0000_0000},
            '{KIND_FIRST_UNUSED, 8'd255, 32'hFFFF_FFFF},
            '{3'd6,       8'd0,   32'h0000_0000},
            '{KIND_LAST_UNUSED,  8'd1,   32'h0000_0001},
            '{OP_INSERT,  8'd255, 32'hFFFF_FFFF},
            '{OP_SELECT,  8'd0,   32'h0000_0000},
            '{OP_SEARCH,  8'd255, 32'hA5A5_A5A5}
        };
        foreach (directed[i])
            offer_request(directed[i]);

        // Random segments alternate between filling, draining and mixed traffic.
        modes = '{MODE_FILL, MODE_DRAIN, MODE_FILL, MODE_MIXED, MODE_DRAIN,
                  MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_MIXED};
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            send_calm = (seg % 3 == 1) || (seg == 2);
            recv_calm = (seg % 3 == 2) && (seg != 2);
            // Hold the receiver off while requests keep coming, so the block backs up.
            if (seg == 2)
                long_hold = 1'b1;
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                offer_request(random_request(modes[seg]));
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding replies, then allow a few cycles for strays.
        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
